@@ src/mmu_pkg.sv @@
`timescale 1ns / 1ps
package mmu_pkg;

  typedef enum logic [1:0] {
    ACT_LOAD_A  = 2'd0,
    ACT_LOAD_B  = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_LEN = 2'd1,
    CFG_COLS_B    = 2'd2,
    CFG_SHIFT     = 2'd3
  } cfg_index_e;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned DimWidth   = 4;
  localparam int unsigned ShiftWidth = 5;
  localparam int unsigned PosWidth   = 3;
  localparam int unsigned OutDataWidth = 40;

  typedef logic [DataWidth-1:0] data_t;
  typedef logic [DimWidth-1:0]  dim_t;

  // Control that travels with each term through the datapath.
  typedef struct packed {
    logic                valid;
    logic                first;
    logic                fin;
    logic                last;
    logic [PosWidth-1:0] row;
    logic [PosWidth-1:0] col;
  } tag_t;

endpackage

@@ src/mmu_store.sv @@
`timescale 1ns / 1ps
module mmu_store #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrWidth = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_en_i,
  input  mmu_pkg::data_t       wr_data_i,
  input  logic                 clear_i,
  input  logic                 rd_en_i,
  input  logic [AddrWidth-1:0] rd_addr_i,
  output mmu_pkg::data_t       rd_data_o
);
  import mmu_pkg::*;

  localparam int unsigned CntWidth = $clog2(Depth + 1);

  data_t               mem [Depth];
  data_t               rd_data_q;
  logic [CntWidth-1:0] count_q, count_d;
  logic                full;

  assign full = (count_q == CntWidth'(Depth));

  always_comb begin
    count_d = count_q;
    if (clear_i) begin
      count_d = '0;
    end else if (wr_en_i && !full) begin
      count_d = count_q + CntWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && !full) begin
      mem[count_q[AddrWidth-1:0]] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/mmu_seq.sv @@
`timescale 1ns / 1ps
module mmu_seq #(
  parameter int unsigned AWidth = 6,
  parameter int unsigned BWidth = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              start_i,
  input  mmu_pkg::dim_t     nr_i,
  input  mmu_pkg::dim_t     nk_i,
  input  mmu_pkg::dim_t     nc_i,
  output logic [AWidth-1:0] a_addr_o,
  output logic [BWidth-1:0] b_addr_o,
  output mmu_pkg::tag_t     tag_o,
  output logic              active_o
);
  import mmu_pkg::*;

  logic              active_q, active_d;
  dim_t              m_q, m_d, o_q, o_d, k_q, k_d;
  logic [AWidth-1:0] a_idx_q, a_idx_d, a_base_q, a_base_d;
  logic [BWidth-1:0] b_idx_q, b_idx_d;
  logic              k_last, o_last, m_last;

  assign k_last = (k_q == nk_i - dim_t'(1));
  assign o_last = (o_q == nc_i - dim_t'(1));
  assign m_last = (m_q == nr_i - dim_t'(1));

  always_comb begin
    active_d = active_q;
    m_d      = m_q;
    o_d      = o_q;
    k_d      = k_q;
    a_idx_d  = a_idx_q;
    a_base_d = a_base_q;
    b_idx_d  = b_idx_q;
    if (start_i) begin
      active_d = 1'b1;
      m_d      = '0;
      o_d      = '0;
      k_d      = '0;
      a_idx_d  = '0;
      a_base_d = '0;
      b_idx_d  = '0;
    end else if (adv_i && active_q) begin
      if (!k_last) begin
        k_d     = k_q + dim_t'(1);
        a_idx_d = a_idx_q + AWidth'(1);
        b_idx_d = b_idx_q + BWidth'(nc_i);
      end else begin
        k_d = '0;
        if (!o_last) begin
          o_d     = o_q + dim_t'(1);
          a_idx_d = a_base_q;
          b_idx_d = BWidth'(o_q) + BWidth'(1);
        end else begin
          o_d     = '0;
          b_idx_d = '0;
          if (!m_last) begin
            m_d      = m_q + dim_t'(1);
            a_base_d = a_base_q + AWidth'(nk_i);
            a_idx_d  = a_base_q + AWidth'(nk_i);
          end else begin
            active_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      m_q      <= '0;
      o_q      <= '0;
      k_q      <= '0;
      a_idx_q  <= '0;
      a_base_q <= '0;
      b_idx_q  <= '0;
    end else begin
      active_q <= active_d;
      m_q      <= m_d;
      o_q      <= o_d;
      k_q      <= k_d;
      a_idx_q  <= a_idx_d;
      a_base_q <= a_base_d;
      b_idx_q  <= b_idx_d;
    end
  end

  assign a_addr_o = a_idx_q;
  assign b_addr_o = b_idx_q;
  assign active_o = active_q;

  always_comb begin
    tag_o       = '0;
    tag_o.valid = active_q;
    tag_o.first = (k_q == '0);
    tag_o.fin   = k_last;
    tag_o.last  = m_last && o_last;
    tag_o.row   = m_q[PosWidth-1:0];
    tag_o.col   = o_q[PosWidth-1:0];
  end

endmodule

@@ src/mmu_mac.sv @@
`timescale 1ns / 1ps
module mmu_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  mmu_pkg::tag_t                    tag_i,
  input  mmu_pkg::data_t                   a_i,
  input  mmu_pkg::data_t                   b_i,
  input  logic [mmu_pkg::ShiftWidth-1:0]   shift_i,
  output logic                             out_valid_o,
  output mmu_pkg::data_t                   out_value_o,
  output logic [mmu_pkg::PosWidth-1:0]     out_row_o,
  output logic [mmu_pkg::PosWidth-1:0]     out_col_o,
  output logic                             out_last_o,
  output logic                             busy_o
);
  import mmu_pkg::*;

  tag_t  tag1_q, tag2_q, tag3_q;
  data_t prod_q, prod_d;
  data_t term_q, term_d;
  data_t acc_q, acc_d;
  data_t rnd, sum_rnd;
  data_t out_value_q;
  logic  out_valid_q, out_last_q;
  logic [PosWidth-1:0] out_row_q, out_col_q;

  assign prod_d  = a_i * b_i;
  assign rnd     = (DataWidth'(1) << shift_i) >> 1;
  assign sum_rnd = prod_q + rnd;
  assign term_d  = data_t'($signed(sum_rnd) >>> shift_i);
  assign acc_d   = (tag3_q.first ? '0 : acc_q) + term_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q      <= '0;
      tag2_q      <= '0;
      tag3_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      tag1_q      <= tag_i;
      tag2_q      <= tag1_q;
      tag3_q      <= tag2_q;
      out_valid_q <= tag3_q.valid && tag3_q.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
      term_q <= term_d;
      if (tag3_q.valid) begin
        acc_q <= acc_d;
      end
      if (tag3_q.valid && tag3_q.fin) begin
        out_value_q <= acc_d;
        out_row_q   <= tag3_q.row;
        out_col_q   <= tag3_q.col;
        out_last_q  <= tag3_q.last;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_last_o  = out_last_q;
  assign busy_o      = tag1_q.valid || tag2_q.valid || tag3_q.valid;

endmodule

@@ src/fixed_point_matrix_multiply_unit.sv @@
`timescale 1ns / 1ps
// Signed 32-bit matrix multiply C = A * B with a rounding right shift on every product.
// Load requests (A or B element, row-major) are accepted while no compute is under way.
// A compute request streams out rows_a * cols_b results in row-major order and keeps the
// unit busy until its last term has left the multiply-accumulate stages, one product per
// cycle, set by the single read port of each element memory feeding one
// multiply-accumulate unit; a stalled result output stalls the pipeline. No clearing pass
// follows reset.
module fixed_point_matrix_multiply_unit #(
  parameter int unsigned MAX_ROWS  = 8,
  parameter int unsigned MAX_INNER = 8,
  parameter int unsigned MAX_COLS  = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [mmu_pkg::ShiftWidth-1:0]      cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mmu_pkg::DataWidth-1:0]       s_axis_tdata,   // element
  input  logic [1:0]                          s_axis_tuser,   // action
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mmu_pkg::OutDataWidth-1:0]    m_axis_tdata,   // product_value, out_row, out_col
  output logic                                m_axis_tlast
);
  import mmu_pkg::*;

  localparam int unsigned ADepth = MAX_ROWS * MAX_INNER;
  localparam int unsigned BDepth = MAX_INNER * MAX_COLS;
  localparam int unsigned AWidth = (ADepth > 1) ? $clog2(ADepth) : 1;
  localparam int unsigned BWidth = (BDepth > 1) ? $clog2(BDepth) : 1;

  dim_t rows_q, inner_q, cols_q;
  logic [ShiftWidth-1:0] shift_q;
  dim_t nr, nk, nc;

  logic accept, load_a, load_b, compute, start, adv;
  logic seq_active, pipe_busy;
  logic [AWidth-1:0] a_addr;
  logic [BWidth-1:0] b_addr;
  data_t a_rd, b_rd, out_value;
  tag_t  tag;
  logic  out_valid, out_last;
  logic [PosWidth-1:0] out_row, out_col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= dim_t'(1);
      inner_q <= dim_t'(1);
      cols_q  <= dim_t'(1);
      shift_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_ROWS_A:    rows_q  <= cfg_data_i[DimWidth-1:0];
        CFG_INNER_LEN: inner_q <= cfg_data_i[DimWidth-1:0];
        CFG_COLS_B:    cols_q  <= cfg_data_i[DimWidth-1:0];
        CFG_SHIFT:     shift_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign nr = (32'(rows_q)  > MAX_ROWS)  ? dim_t'(MAX_ROWS)  : rows_q;
  assign nk = (32'(inner_q) > MAX_INNER) ? dim_t'(MAX_INNER) : inner_q;
  assign nc = (32'(cols_q)  > MAX_COLS)  ? dim_t'(MAX_COLS)  : cols_q;

  assign s_axis_tready = !(seq_active || pipe_busy);
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign load_a  = accept && (s_axis_tuser == ACT_LOAD_A);
  assign load_b  = accept && (s_axis_tuser == ACT_LOAD_B);
  assign compute = accept && (s_axis_tuser == ACT_COMPUTE);
  assign start   = compute && (nr != '0) && (nk != '0) && (nc != '0);
  assign adv     = !out_valid || m_axis_tready;

  mmu_store #(
    .Depth(ADepth),
    .AddrWidth(AWidth)
  ) u_store_a (
    .clk_i,
    .rst_ni,
    .wr_en_i  (load_a),
    .wr_data_i(s_axis_tdata),
    .clear_i  (compute),
    .rd_en_i  (adv),
    .rd_addr_i(a_addr),
    .rd_data_o(a_rd)
  );

  mmu_store #(
    .Depth(BDepth),
    .AddrWidth(BWidth)
  ) u_store_b (
    .clk_i,
    .rst_ni,
    .wr_en_i  (load_b),
    .wr_data_i(s_axis_tdata),
    .clear_i  (compute),
    .rd_en_i  (adv),
    .rd_addr_i(b_addr),
    .rd_data_o(b_rd)
  );

  mmu_seq #(
    .AWidth(AWidth),
    .BWidth(BWidth)
  ) u_seq (
    .clk_i,
    .rst_ni,
    .adv_i   (adv),
    .start_i (start),
    .nr_i    (nr),
    .nk_i    (nk),
    .nc_i    (nc),
    .a_addr_o(a_addr),
    .b_addr_o(b_addr),
    .tag_o   (tag),
    .active_o(seq_active)
  );

  mmu_mac u_mac (
    .clk_i,
    .rst_ni,
    .adv_i      (adv),
    .tag_i      (tag),
    .a_i        (a_rd),
    .b_i        (b_rd),
    .shift_i    (shift_q),
    .out_valid_o(out_valid),
    .out_value_o(out_value),
    .out_row_o  (out_row),
    .out_col_o  (out_col),
    .out_last_o (out_last),
    .busy_o     (pipe_busy)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_col, out_row, out_value};
  assign m_axis_tlast  = out_last;

endmodule

@@ src/mmu_checker.sv @@
`timescale 1ns / 1ps
module mmu_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [1:0]                       s_axis_tuser,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [mmu_pkg::OutDataWidth-1:0] m_axis_tdata,
  input logic                             m_axis_tlast
);
  import mmu_pkg::*;

  logic load_req;

  assign load_req = s_axis_tvalid && s_axis_tready &&
                    ((s_axis_tuser == ACT_LOAD_A) || (s_axis_tuser == ACT_LOAD_B));

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_req |=> !$rose(m_axis_tvalid))
    else $error("result appeared after a load request");

  a_busy_after_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_req |=> !(m_axis_tvalid && !$past(m_axis_tvalid)))
    else $error("load request started result traffic");

  a_last_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !(m_axis_tvalid && m_axis_tlast
      && $past(s_axis_tuser) != ACT_COMPUTE))
    else $error("final result without a compute request");

endmodule

bind fixed_point_matrix_multiply_unit mmu_checker u_mmu_checker (.*);
